[rtl/mmcd_pkg.sv]
// mmcd_pkg: shared constants for the min/max column decimator.
// Used by mmcd_front, mmcd_back and the top level; has no dependencies of its own.
package mmcd_pkg;

   localparam int COORD_WIDTH_DEF = 32;  // default coordinate width
   localparam int QUEUE_DEPTH_DEF = 4;   // points held between front and back
   localparam int COL_W           = 16;  // columns register width
   localparam int COUNT_W         = 32;  // point_count register width
   localparam int COLUMN_W        = 64;  // bucket column index width
   localparam int MAX_RESULTS     = 3;   // results one point can cause
   localparam int RCNT_W          = $clog2(MAX_RESULTS + 1);
   localparam int CSR_INDEX_W     = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PLOT_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLOT_RIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMNS     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_POINT_COUNT = 2'd3;

endpackage

[rtl/mmcd_front.sv]
// mmcd_front: accepts points, decides pass-through, computes the screen column
// with a shared bit-serial divider. Depends on mmcd_pkg.
module mmcd_front
   #(parameter int CW = mmcd_pkg::COORD_WIDTH_DEF)
   (input  logic                           clock,
    input  logic                           reset,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [CW-1:0]                  req_x,
    input  logic [CW-1:0]                  req_y,
    input  logic                           req_last,
    input  logic [CW-1:0]                  plot_left,
    input  logic [CW-1:0]                  plot_right,
    input  logic [mmcd_pkg::COL_W-1:0]     columns,
    input  logic [mmcd_pkg::COUNT_W-1:0]   point_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [CW-1:0]                  out_x,
    output logic [CW-1:0]                  out_y,
    output logic                           out_last,
    output logic                           out_bypass,
    output logic [mmcd_pkg::COLUMN_W-1:0]  out_column);

   import mmcd_pkg::*;

   localparam int DW    = CW + COL_W;                // divider dividend width
   localparam int CNT_W = $clog2(DW);
   localparam int WIDE  = (CW + COL_W + 2 > 66) ? CW + COL_W + 2 : 66;

   localparam logic signed [WIDE-1:0] SAT_HI =
      {{(WIDE-COLUMN_W){1'b0}}, 1'b0, {(COLUMN_W-1){1'b1}}};
   localparam logic signed [WIDE-1:0] SAT_LO =
      {{(WIDE-COLUMN_W){1'b1}}, 1'b1, {(COLUMN_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_DIV_A, ST_FLOOR, ST_MUL, ST_DIV_B, ST_FIN, ST_PUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           x_ff, x_in, y_ff, y_in;
   logic                    last_ff, last_in, bypass_ff, bypass_in, neg_ff, neg_in;
   logic [CW:0]             d_ff, d_in;
   logic [CW-1:0]           span_ff, span_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [CW:0]      q_ff, q_in;
   logic signed [WIDE-1:0]  prod_ff, prod_in;
   logic [COLUMN_W-1:0]     col_ff, col_in;

   logic                    bypass_now;
   logic [CW:0]             shl, diff, mag_d, qmag;
   logic                    ge;
   logic signed [WIDE-1:0]  q_wide, c_wide, frac_wide, sum_w;
   logic [DW-1:0]           r_dw, c_dw;
   logic                    sat_hi, sat_lo, fold;

   assign bypass_now = (columns == '0) ||
                       !($signed(plot_right) > $signed(plot_left)) ||
                       (point_count <= {{(COUNT_W-COL_W){1'b0}}, columns});

   // restoring divide step, one quotient bit a cycle
   assign shl  = {rem_ff, quo_ff[DW-1]};
   assign ge   = shl >= {1'b0, span_ff};
   assign diff = shl - {1'b0, span_ff};

   assign mag_d = d_ff[CW] ? (~d_ff + 1'b1) : d_ff;
   assign qmag  = {1'b0, quo_ff[CW-1:0]};

   assign q_wide    = WIDE'(q_ff);
   assign c_wide    = {{(WIDE-COL_W){1'b0}}, columns};
   assign r_dw      = {{COL_W{1'b0}}, rem_ff};
   assign c_dw      = {{CW{1'b0}}, columns};
   assign frac_wide = {{(WIDE-COL_W){1'b0}}, quo_ff[COL_W-1:0]};
   assign sum_w     = prod_ff + frac_wide;
   assign sat_hi    = (prod_ff > SAT_HI) || (sum_w > SAT_HI);
   assign sat_lo    = prod_ff < SAT_LO;
   // right edge folds into the last column
   assign fold      = (sum_w == c_wide) && (x_ff == plot_right);

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      last_in   = last_ff;
      bypass_in = bypass_ff;
      neg_in    = neg_ff;
      d_in      = d_ff;
      span_in   = span_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      prod_in   = prod_ff;
      col_in    = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in      = req_x;
               y_in      = req_y;
               last_in   = req_last;
               bypass_in = bypass_now;
               d_in      = {req_x[CW-1], req_x} - {plot_left[CW-1], plot_left};
               span_in   = plot_right - plot_left;
               state_in  = bypass_now ? ST_PUSH : ST_PREP;
            end
         end
         ST_PREP: begin
            quo_in   = {{COL_W{1'b0}}, mag_d[CW-1:0]};
            rem_in   = '0;
            cnt_in   = '0;
            neg_in   = d_ff[CW];
            state_in = ST_DIV_A;
         end
         ST_DIV_A, ST_DIV_B: begin
            rem_in = ge ? diff[CW-1:0] : shl[CW-1:0];
            quo_in = {quo_ff[DW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DW - 1)) begin
               state_in = (state_ff == ST_DIV_A) ? ST_FLOOR : ST_FIN;
            end
         end
         ST_FLOOR: begin
            // floor toward minus infinity for a negative offset
            if (neg_ff) begin
               if (rem_ff == '0) begin
                  q_in = ~qmag + 1'b1;
               end else begin
                  q_in   = ~qmag;
                  rem_in = span_ff - rem_ff;
               end
            end else begin
               q_in = qmag;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = q_wide * c_wide;
            quo_in   = r_dw * c_dw;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV_B;
         end
         ST_FIN: begin
            if (sat_hi) begin
               col_in = SAT_HI[COLUMN_W-1:0];
            end else if (sat_lo) begin
               col_in = SAT_LO[COLUMN_W-1:0];
            end else if (fold) begin
               col_in = {{(COLUMN_W-COL_W){1'b0}}, columns - COL_W'(1)};
            end else begin
               col_in = sum_w[COLUMN_W-1:0];
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      bypass_ff <= bypass_in;
      neg_ff    <= neg_in;
      d_ff      <= d_in;
      span_ff   <= span_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      q_ff      <= q_in;
      prod_ff   <= prod_in;
      col_ff    <= col_in;
   end

   assign req_ready  = state_ff == ST_IDLE;
   assign out_valid  = state_ff == ST_PUSH;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_last   = last_ff;
   assign out_bypass = bypass_ff;
   assign out_column = col_ff;

endmodule

[rtl/mmcd_queue.sv]
// mmcd_queue: small register FIFO between the column front end and the
// bucket back end. Depends on nothing but its parameters.
module mmcd_queue
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 4)
   (input  logic             clock,
    input  logic             reset,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = cnt_ff != CNT_W'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

endmodule

[rtl/mmcd_back.sv]
// mmcd_back: min/max bucket per column run and the result buffer that
// drives the result channel. Depends on mmcd_pkg.
module mmcd_back
   #(parameter int CW = mmcd_pkg::COORD_WIDTH_DEF)
   (input  logic                           clock,
    input  logic                           reset,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [CW-1:0]                  in_x,
    input  logic [CW-1:0]                  in_y,
    input  logic                           in_last,
    input  logic                           in_bypass,
    input  logic [mmcd_pkg::COLUMN_W-1:0]  in_column,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [CW-1:0]                  rsp_x,
    output logic [CW-1:0]                  rsp_y,
    output logic                           rsp_last);

   import mmcd_pkg::*;

   // bucket state
   logic                open_ff, open_in;
   logic [COLUMN_W-1:0] column_ff, column_in;
   logic [CW-1:0]       low_x_ff, low_x_in, low_y_ff, low_y_in;
   logic [CW-1:0]       high_x_ff, high_x_in, high_y_ff, high_y_in;
   logic                low_first_ff, low_first_in, single_ff, single_in;

   // result buffer, slot 0 faces the channel
   logic [CW-1:0]       sx_ff [MAX_RESULTS];
   logic [CW-1:0]       sy_ff [MAX_RESULTS];
   logic                sl_ff [MAX_RESULTS];
   logic [CW-1:0]       sx_in [MAX_RESULTS];
   logic [CW-1:0]       sy_in [MAX_RESULTS];
   logic                sl_in [MAX_RESULTS];
   logic [RCNT_W-1:0]   cnt_ff, cnt_in;

   // results of the point at the queue head
   logic [CW-1:0]       lx [MAX_RESULTS];
   logic [CW-1:0]       ly [MAX_RESULTS];
   logic                ll [MAX_RESULTS];
   logic [RCNT_W-1:0]   k;
   logic                new_bucket, pop;

   assign in_ready = (cnt_ff == '0) || ((cnt_ff == RCNT_W'(1)) && rsp_ready);
   assign pop      = in_valid && in_ready;

   always_comb begin
      open_in      = open_ff;
      column_in    = column_ff;
      low_x_in     = low_x_ff;
      low_y_in     = low_y_ff;
      high_x_in    = high_x_ff;
      high_y_in    = high_y_ff;
      low_first_in = low_first_ff;
      single_in    = single_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         lx[i] = '0;
         ly[i] = '0;
         ll[i] = 1'b0;
      end
      k          = '0;
      new_bucket = !open_ff || (in_column != column_ff);

      if (in_bypass) begin
         lx[0] = in_x;
         ly[0] = in_y;
         ll[0] = in_last;
         k     = RCNT_W'(1);
         if (in_last) begin
            open_in = 1'b0;
         end
      end else begin
         // column changed: flush the old bucket first
         if (new_bucket && open_ff) begin
            if (single_ff) begin
               lx[k] = low_x_ff;  ly[k] = low_y_ff;  k = k + 1'b1;
            end else if (low_first_ff) begin
               lx[k] = low_x_ff;  ly[k] = low_y_ff;  k = k + 1'b1;
               lx[k] = high_x_ff; ly[k] = high_y_ff; k = k + 1'b1;
            end else begin
               lx[k] = high_x_ff; ly[k] = high_y_ff; k = k + 1'b1;
               lx[k] = low_x_ff;  ly[k] = low_y_ff;  k = k + 1'b1;
            end
         end
         if (new_bucket) begin
            column_in    = in_column;
            low_x_in     = in_x;
            low_y_in     = in_y;
            high_x_in    = in_x;
            high_y_in    = in_y;
            single_in    = 1'b1;
            low_first_in = 1'b0;
         end else if ($signed(in_y) < $signed(low_y_ff)) begin
            low_x_in     = in_x;
            low_y_in     = in_y;
            single_in    = 1'b0;
            low_first_in = 1'b0;
         end else if ($signed(in_y) > $signed(high_y_ff)) begin
            high_x_in    = in_x;
            high_y_in    = in_y;
            single_in    = 1'b0;
            low_first_in = 1'b1;
         end
         open_in = 1'b1;
         // end of series: flush the updated bucket, mark the final result
         if (in_last) begin
            if (single_in) begin
               lx[k] = low_x_in;  ly[k] = low_y_in;  k = k + 1'b1;
            end else if (low_first_in) begin
               lx[k] = low_x_in;  ly[k] = low_y_in;  k = k + 1'b1;
               lx[k] = high_x_in; ly[k] = high_y_in; k = k + 1'b1;
            end else begin
               lx[k] = high_x_in; ly[k] = high_y_in; k = k + 1'b1;
               lx[k] = low_x_in;  ly[k] = low_y_in;  k = k + 1'b1;
            end
            ll[k - 1'b1] = 1'b1;
            open_in      = 1'b0;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         sx_in[i] = sx_ff[i];
         sy_in[i] = sy_ff[i];
         sl_in[i] = sl_ff[i];
      end
      if (pop) begin
         cnt_in = k;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            sx_in[i] = lx[i];
            sy_in[i] = ly[i];
            sl_in[i] = ll[i];
         end
      end else if ((cnt_ff != '0) && rsp_ready) begin
         cnt_in = cnt_ff - 1'b1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            sx_in[i] = sx_ff[i+1];
            sy_in[i] = sy_ff[i+1];
            sl_in[i] = sl_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) begin
            open_ff <= open_in;
         end
      end
      if (pop) begin
         column_ff    <= column_in;
         low_x_ff     <= low_x_in;
         low_y_ff     <= low_y_in;
         high_x_ff    <= high_x_in;
         high_y_ff    <= high_y_in;
         low_first_ff <= low_first_in;
         single_ff    <= single_in;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         sx_ff[i] <= sx_in[i];
         sy_ff[i] <= sy_in[i];
         sl_ff[i] <= sl_in[i];
      end
   end

   assign rsp_valid = cnt_ff != '0;
   assign rsp_x     = sx_ff[0];
   assign rsp_y     = sy_ff[0];
   assign rsp_last  = sl_ff[0];

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      pop && in_last |=> !open_ff)
      else $error("bucket still open after end of series");

   a_point_opens: assert property (@(posedge clock) disable iff (reset)
      pop && !in_bypass && !in_last |=> open_ff)
      else $error("binned point left no open bucket");

   a_must_emit: assert property (@(posedge clock) disable iff (reset)
      pop && (in_bypass || in_last) |=> cnt_ff != '0)
      else $error("pass-through or final point produced no result");

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && sl_ff[0] |-> cnt_ff == RCNT_W'(1))
      else $error("series end flag on a result that is not the final one");

endmodule

[rtl/min_max_column_decimator.sv]
// min_max_column_decimator: top level of the min/max column decimator.
// Holds the configuration registers and wires mmcd_front, mmcd_queue and
// mmcd_back together. Depends on mmcd_pkg.
//
// Usage
//   req_*: one (x, y) point per transaction, req_tlast marks the final point
//     of a series. rsp_*: decimated points, rsp_tlast on the final result
//     caused by the end-of-series point. A point yields 0 to 3 results.
//   csr_*: register writes, always ready, to be done while the block is idle.
//     Index 0 plot_left, 1 plot_right, 2 columns, 3 point_count.
//   Pass-through (columns 0, plot_right <= plot_left or point_count not above
//     columns): each point comes out unchanged.
// Timing
//   A binned point occupies the front end for two passes of the one-bit-a-cycle
//   divider; the front end takes no new point until it has handed the current
//   one to the queue, and a pass-through point goes straight to that hand-over.
// Reset clears the configuration registers and control state: pass-through mode, no open bucket.
// When rsp_tready is low the back end holds its results, the queue fills
// with up to QUEUE_DEPTH points, then req_tready drops.
module min_max_column_decimator
   #(parameter int COORD_WIDTH = mmcd_pkg::COORD_WIDTH_DEF,
     parameter int QUEUE_DEPTH = mmcd_pkg::QUEUE_DEPTH_DEF)
   (input  logic                               clock,
    input  logic                               reset,
    // req_tdata: pos_x, pos_y (low bit first), zero padded to whole bytes
    input  logic                               req_tvalid,
    output logic                               req_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
    input  logic                               req_tlast,
    // rsp_tdata: out_x, out_y (low bit first), zero padded to whole bytes
    output logic                               rsp_tvalid,
    input  logic                               rsp_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
    output logic                               rsp_tlast,
    input  logic                               csr_valid,
    output logic                               csr_ready,
    input  logic [mmcd_pkg::CSR_INDEX_W-1:0]   csr_index,
    input  logic [((COORD_WIDTH > mmcd_pkg::COUNT_W) ?
                   COORD_WIDTH : mmcd_pkg::COUNT_W)-1:0] csr_data);

   import mmcd_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int ENTRY_W = 2*CW + 2 + COLUMN_W;

   // configuration registers
   logic [CW-1:0]      plot_left_ff, plot_right_ff;
   logic [COL_W-1:0]   columns_ff;
   logic [COUNT_W-1:0] point_count_ff;

   // front end -> queue
   logic                f_valid, f_ready, f_last, f_bypass;
   logic [CW-1:0]       f_x, f_y;
   logic [COLUMN_W-1:0] f_column;
   logic [ENTRY_W-1:0]  f_entry, b_entry;

   // queue -> back end
   logic                b_valid, b_ready;

   // back end -> result channel
   logic [CW-1:0]       r_x, r_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plot_left_ff   <= '0;
         plot_right_ff  <= '0;
         columns_ff     <= '0;
         point_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PLOT_LEFT:   plot_left_ff   <= csr_data[CW-1:0];
            REG_PLOT_RIGHT:  plot_right_ff  <= csr_data[CW-1:0];
            REG_COLUMNS:     columns_ff     <= csr_data[COL_W-1:0];
            REG_POINT_COUNT: point_count_ff <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mmcd_front #(.CW(CW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_x       (req_tdata[CW-1:0]),
      .req_y       (req_tdata[2*CW-1:CW]),
      .req_last    (req_tlast),
      .plot_left   (plot_left_ff),
      .plot_right  (plot_right_ff),
      .columns     (columns_ff),
      .point_count (point_count_ff),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .out_x       (f_x),
      .out_y       (f_y),
      .out_last    (f_last),
      .out_bypass  (f_bypass),
      .out_column  (f_column));

   assign f_entry = {f_column, f_bypass, f_last, f_y, f_x};

   mmcd_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_entry),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_entry));

   mmcd_back #(.CW(CW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_x      (b_entry[CW-1:0]),
      .in_y      (b_entry[2*CW-1:CW]),
      .in_last   (b_entry[2*CW]),
      .in_bypass (b_entry[2*CW+1]),
      .in_column (b_entry[ENTRY_W-1:2*CW+2]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (r_x),
      .rsp_y     (r_y),
      .rsp_last  (rsp_tlast));

   always_comb begin
      rsp_tdata           = '0;
      rsp_tdata[2*CW-1:0] = {r_y, r_x};
   end

endmodule

[bench/min_max_column_decimator_test.sv]
// Testbench for min_max_column_decimator: directed and random point series,
// checked against a bucket predictor in a small scoreboard class.
// Depends on mmcd_pkg and the block's RTL; needs no files or arguments.
module min_max_column_decimator_test;
   import mmcd_pkg::*;

   localparam int CW     = COORD_WIDTH_DEF;
   localparam int DATA_W = ((2*CW+7)/8)*8;
   // front end holds a binned point this long; add margin for the back end
   localparam int SETTLE_CYCLES    = 2*(CW+16)+6+50;
   localparam int ITEM_TARGET      = 320;
   localparam int MAX_REPORT_LINES = 200;
   localparam longint COORD_LO     = -64'sd2147483648;
   localparam longint COORD_HI     = 64'sd2147483647;
   localparam longint I64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN      = -I64_MAX - 1;

   typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          last;
   } screen_point_type;

   // Predicts decimated points from accepted input transactions and holds
   // them until the matching result transaction shows up.
   class decimation_tracker_type;
      longint           left_x, right_x;
      longint unsigned  column_total, series_length;
      bit               have_bucket;
      longint           bucket_col;
      longint           min_x, min_y, max_x, max_y;
      bit               min_first, lone_point;
      screen_point_type due_points[$];
      int               mismatches;

      function new();
         left_x = 0;
         right_x = 0;
         column_total = 0;
         series_length = 0;
         have_bucket = 0;
         bucket_col = 0;
         min_x = 0;
         min_y = 0;
         max_x = 0;
         max_y = 0;
         min_first = 0;
         lone_point = 1;
         mismatches = 0;
      endfunction

      function int pending();
         return due_points.size();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORT_LINES)
            $display("mismatch: %s", msg);
      endtask

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CW-1:0] value);
         case (index)
            REG_PLOT_LEFT:   left_x = $signed(value);
            REG_PLOT_RIGHT:  right_x = $signed(value);
            REG_COLUMNS:     column_total = value[COL_W-1:0];
            REG_POINT_COUNT: series_length = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // floor((x - left) * columns / span), exact, saturating to 64 bits
      function longint column_index(longint x);
         longint span, delta, q, r, c, frac, base;
         span = right_x - left_x;
         delta = x - left_x;
         q = delta / span;
         r = delta % span;
         c = longint'(column_total);
         if (r < 0) begin
            q = q - 1;
            r = r + span;
         end
         frac = $signed(($unsigned(r) * column_total) / $unsigned(span));
         if (q > 0 && q > I64_MAX / c)
            return I64_MAX;
         if (q < 0 && q < I64_MIN / c)
            return I64_MIN;
         base = q * c;
         if (base > I64_MAX - frac)
            return I64_MAX;
         base = base + frac;
         // right edge folds into the last column
         if (base == c && x == right_x)
            base = c - 1;
         return base;
      endfunction

      function void expect_point(longint x, longint y, logic last);
         due_points.push_back('{x: x[CW-1:0], y: y[CW-1:0], last: last});
      endfunction

      // emit the kept points of the open bucket in arrival order
      function void close_bucket();
         if (!have_bucket)
            return;
         if (lone_point) begin
            expect_point(min_x, min_y, 1'b0);
         end else if (min_first) begin
            expect_point(min_x, min_y, 1'b0);
            expect_point(max_x, max_y, 1'b0);
         end else begin
            expect_point(max_x, max_y, 1'b0);
            expect_point(min_x, min_y, 1'b0);
         end
         have_bucket = 0;
      endfunction

      function void note_point(logic [CW-1:0] px, logic [CW-1:0] py, logic last);
         longint x, y, col;
         screen_point_type tail;
         x = $signed(px);
         y = $signed(py);
         if (column_total == 0 || right_x <= left_x ||
             series_length <= column_total) begin
            // pass-through; end of series drops any open bucket
            expect_point(x, y, last);
            if (last)
               have_bucket = 0;
            return;
         end
         col = column_index(x);
         if (!have_bucket || col != bucket_col) begin
            close_bucket();
            have_bucket = 1;
            bucket_col = col;
            min_x = x;
            max_x = x;
            min_y = y;
            max_y = y;
            lone_point = 1;
            min_first = 0;
         end else if (y < min_y) begin
            min_x = x;
            min_y = y;
            lone_point = 0;
            min_first = 0;
         end else if (y > max_y) begin
            max_x = x;
            max_y = y;
            lone_point = 0;
            min_first = 1;
         end
         if (last) begin
            close_bucket();
            tail = due_points.pop_back();
            tail.last = 1'b1;
            due_points.push_back(tail);
         end
      endfunction

      task match_result(logic [CW-1:0] gx, logic [CW-1:0] gy, logic glast);
         screen_point_type want;
         if (due_points.size() == 0) begin
            report_mismatch($sformatf("result x=%h y=%h last=%b with nothing pending",
                                      gx, gy, glast));
            return;
         end
         want = due_points.pop_front();
         if (gx !== want.x)
            report_mismatch($sformatf("out_x got %h expected %h", gx, want.x));
         if (gy !== want.y)
            report_mismatch($sformatf("out_y got %h expected %h", gy, want.y));
         if (glast !== want.last)
            report_mismatch($sformatf("run_last got %b expected %b", glast, want.last));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   // req_tdata: pos_x [31:0], pos_y [63:32]; req_tlast: end_of_series
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata = '0;
   logic                   req_tlast = 1'b0;
   // rsp_tdata: out_x [31:0], out_y [63:32]; rsp_tlast: run_last
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_PLOT_LEFT;
   logic [CW-1:0]          csr_data = '0;

   decimation_tracker_type tracker;

   // sender and current configuration as seen by the stimulus
   int           burst_left = 0;
   int           sent_items = 0;
   longint       cfg_left = 0;
   longint       cfg_right = 0;
   int           cfg_cols = 0;

   // receiver stall pattern
   int           stall_left = 0;
   int           stall_span = 0;
   int           stall_style = 0;

   min_max_column_decimator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: styles rotate after spans of random length - always ready,
   // short frequent stalls, or long rare stalls.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_span = $urandom_range(50, 400);
      end
      stall_span--;
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         case (stall_style)
            1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 2);
            2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
            default: ;
         endcase
      end
   end

   // Monitor: every transaction is sampled at the edge that completes it.
   // Inputs are noted before results are matched within the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.set_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            tracker.note_point(req_tdata[CW-1:0], req_tdata[2*CW-1:CW], req_tlast);
         if (rsp_tvalid && rsp_tready)
            tracker.match_result(rsp_tdata[CW-1:0], rsp_tdata[2*CW-1:CW], rsp_tlast);
      end
   end

   // One point transaction; the sender may idle between bursts of random length.
   // valid stays high across back-to-back calls inside a burst.
   task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic last);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // Sender goes quiet until every predicted point has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // csr_valid is left high between writes; configure() drops it at the end
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [CW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers change only with the block idle: drained, then the front end
   // given time to finish a point that produced nothing. An open bucket
   // survives this on purpose.
   task automatic configure(input longint left, input longint right,
                            input logic [15:0] cols, input logic [31:0] count);
      logic [31:0] junk;
      junk = $urandom;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      cfg_left = left;
      cfg_right = right;
      cfg_cols = cols;
      write_reg(REG_PLOT_LEFT, left[CW-1:0]);
      write_reg(REG_PLOT_RIGHT, right[CW-1:0]);
      // upper bits of the columns write are don't-care
      write_reg(REG_COLUMNS, {junk[31:16], cols});
      write_reg(REG_POINT_COUNT, count);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One random configuration and a series of points under it. Most x
   // values sweep rightward so that columns collect runs of points.
   task automatic random_phase();
      int          kind, pick, n, ending;
      longint      span, room, left, right, cur, xv, yv, max_step;
      logic [15:0] cols;
      logic [31:0] count;
      logic        last;
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (pick < 60)      cols = $urandom_range(1, 16);
      else if (pick < 80) cols = $urandom_range(17, 300);
      else if (pick < 90) cols = 16'hFFFF;
      else                cols = $urandom_range(1, 65535);
      pick = $urandom_range(0, 99);
      if (pick < 50)      span = $urandom_range(1, 4000);
      else if (pick < 75) span = $urandom_range(1, 1 << 20);
      else if (pick < 90) span = $urandom_range(1, 32'hFFFF_FFFF);
      else                span = 64'hFFFF_FFFF;
      room = 64'hFFFF_FFFF - span;
      left = COORD_LO + longint'($urandom_range(0, room[31:0]));
      right = left + span;
      pick = $urandom_range(0, 99);
      if (pick < 85)      count = cols + $urandom_range(1, 1000);
      else if (pick < 95) count = 32'hFFFF_FFFF;
      else                count = cols + 1;
      if (kind < 12) begin
         // pass-through, reached each of the three ways
         case ($urandom_range(0, 2))
            0: begin
               cols = 16'd0;
               count = $urandom;
            end
            1: begin
               left = longint'($signed($urandom));
               right = left - longint'($urandom_range(0, 1000));
               if (right < COORD_LO)
                  right = COORD_LO;
            end
            default: count = $urandom_range(0, cols);
         endcase
      end
      configure(left, right, cols, count);

      if (cfg_cols != 0 && cfg_right > cfg_left)
         max_step = (cfg_right - cfg_left) / cfg_cols / 2 + 1;
      else
         max_step = 1000;
      cur = cfg_left - $urandom_range(0, 3);
      n = $urandom_range(6, 40);
      ending = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            cur = cur + longint'($urandom_range(0, max_step[31:0]));
            if (cur > cfg_right)
               cur = cfg_left;
            xv = cur;
         end else if (pick < 78) begin
            xv = cfg_right;
         end else if (pick < 84) begin
            xv = cfg_left;
         end else if (pick < 92) begin
            xv = longint'($signed($urandom));
         end else if (pick[0]) begin
            xv = cfg_right + 1 + $urandom_range(0, 100);
         end else begin
            xv = cfg_left - 1 - $urandom_range(0, 100);
         end
         pick = $urandom_range(0, 99);
         if (pick < 60)      yv = longint'($signed($urandom));
         else if (pick < 80) yv = longint'($urandom_range(0, 3)) - 1;  // ties
         else if (pick < 87) yv = COORD_LO;
         else if (pick < 94) yv = COORD_HI;
         else                yv = 0;
         // occasional end mark inside the series; some series never end
         last = (i == n-1 && ending != 0) || $urandom_range(0, 49) == 0;
         if ($urandom_range(0, 49) == 0)
            wait_drained();
         send_point(xv[CW-1:0], yv[CW-1:0], last);
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state is pass-through: coordinate extremes come out unchanged
      send_point(COORD_LO[CW-1:0], COORD_HI[CW-1:0], 1'b0);
      send_point(COORD_HI[CW-1:0], COORD_LO[CW-1:0], 1'b1);

      // ten columns of width 10: low then high, tie keeps the earlier point,
      // high then low, right edge, off-plot on both sides
      configure(0, 100, 16'd10, 32'd1000);
      send_point(32'd0, 32'd5, 1'b0);
      send_point(32'd3, 32'd5, 1'b0);
      send_point(32'd5, -32'sd3, 1'b0);
      send_point(32'd9, 32'd8, 1'b0);
      send_point(32'd10, 32'd7, 1'b0);
      send_point(32'd20, 32'd9, 1'b0);
      send_point(32'd21, 32'd1, 1'b0);
      send_point(32'd100, 32'd4, 1'b0);
      send_point(32'd101, 32'd0, 1'b0);
      send_point(-32'sd1, 32'd0, 1'b0);
      send_point(-32'sd1, 32'd4, 1'b1);

      // full coordinate range, max columns; the end point opens a new column
      // and so yields three results
      configure(COORD_LO, COORD_HI, 16'hFFFF, 32'd65536);
      send_point(COORD_LO[CW-1:0], COORD_HI[CW-1:0], 1'b0);
      send_point(COORD_LO[CW-1:0], COORD_LO[CW-1:0], 1'b0);
      send_point(COORD_HI[CW-1:0], 32'd0, 1'b1);

      // configuration change with a bucket open keeps its column number
      configure(0, 1000, 16'd4, 32'd5);
      send_point(32'd100, 32'd10, 1'b0);
      send_point(32'd150, 32'd20, 1'b0);
      configure(0, 2000, 16'd4, 32'd5);
      send_point(32'd300, -32'sd5, 1'b1);

      // pass-through end mark (point_count equal to columns) drops the bucket
      configure(0, 1000, 16'd4, 32'd100);
      send_point(32'd10, 32'd1, 1'b0);
      configure(0, 1000, 16'd4, 32'd4);
      send_point(32'd20, 32'd2, 1'b1);
      configure(0, 1000, 16'd4, 32'd100);
      send_point(32'd30, 32'd3, 1'b1);

      // empty plot width selects pass-through
      configure(5, 5, 16'd8, 32'd100);
      send_point(32'd5, 32'd7, 1'b1);

      while (sent_items < ITEM_TARGET)
         random_phase();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // run limit: several times the slowest legal run
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
